### rtl/fdt_pkg.sv
package fdt_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int QDEPTH = 2;

    localparam logic [2:0] KIND_REG   = 3'd0;
    localparam logic [2:0] KIND_SRCH  = 3'd1;
    localparam logic [2:0] KIND_DEREG = 3'd2;
    localparam logic [2:0] KIND_LIST  = 3'd3;

    localparam logic [1:0] ST_ACK  = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_HIT  = 2'd2;
    localparam logic [1:0] ST_NAME = 2'd3;

    typedef enum logic [1:0] {
        OP_REG   = 2'd0,
        OP_SRCH  = 2'd1,
        OP_DEREG = 2'd2,
        OP_LIST  = 2'd3
    } t_op;

    typedef struct packed {
        logic        bad;
        t_op         op;
        logic [63:0] peer_low;
        logic [15:0] peer_high;
        logic [63:0] file_low;
        logic [15:0] file_high;
        logic [31:0] ip;
        logic [15:0] port;
    } t_req;

    typedef struct packed {
        logic [63:0] peer_low;
        logic [15:0] peer_high;
        logic [63:0] file_low;
        logic [15:0] file_high;
        logic [31:0] ip;
        logic [15:0] port;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int REQ_W = $bits(t_req);

endpackage

### rtl/fdt_ram.sv
module fdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/fdt_front.sv
module fdt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_busy,
    input  logic [2:0]          i_kind,
    input  logic [63:0]         i_peer_low,
    input  logic [15:0]         i_peer_high,
    input  logic [63:0]         i_file_low,
    input  logic [15:0]         i_file_high,
    input  logic [31:0]         i_ip,
    input  logic [15:0]         i_port,
    output logic                o_q_valid,
    output fdt_pkg::t_req       o_q_req,
    input  logic                i_q_pop
);
    import fdt_pkg::*;

    t_req        r_q [QDEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_req        w_req;
    logic        w_push;

    always_comb begin
        w_req.bad       = 1'b0;
        w_req.op        = OP_REG;
        case (i_kind)
            KIND_REG:   w_req.op = OP_REG;
            KIND_SRCH:  w_req.op = OP_SRCH;
            KIND_DEREG: w_req.op = OP_DEREG;
            KIND_LIST:  w_req.op = OP_LIST;
            default:    w_req.bad = 1'b1;
        endcase
        w_req.peer_low  = i_peer_low;
        w_req.peer_high = i_peer_high;
        w_req.file_low  = i_file_low;
        w_req.file_high = i_file_high;
        w_req.ip        = i_ip;
        w_req.port      = i_port;
    end

    assign o_busy    = (r_cnt == 2'(QDEPTH));
    assign w_push    = i_valid && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

### rtl/fdt_back.sv
module fdt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  fdt_pkg::t_req i_q_req,
    output logic          o_q_pop,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic [63:0]   o_peer_low,
    output logic [15:0]   o_peer_high,
    output logic [63:0]   o_file_low,
    output logic [15:0]   o_file_high,
    output logic [31:0]   o_ip,
    output logic [15:0]   o_port,
    output logic          o_last
);
    import fdt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_INNER  = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_FLUSH  = 7'b1000000
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_pend;
    logic              r_found;
    logic [IDX_W-1:0]  r_hit;
    t_entry            r_cand;
    logic              r_dup;
    logic              r_any;
    logic              r_cvalid;
    logic [63:0]       r_cfl;
    logic [15:0]       r_cfh;
    logic              r_ofl_v;
    logic [63:0]       r_pfl;
    logic [15:0]       r_pfh;

    logic              r_ov;
    logic [1:0]        r_ost;
    t_entry            r_oe;
    logic              r_olast;

    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    logic [IDX_W-1:0]  w_raddr;
    t_entry            w_rdata;
    logic              w_pair, w_fmatch;

    fdt_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IDX_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_pair = (w_rdata.peer_low == r_req.peer_low) &&
                    (w_rdata.peer_high == r_req.peer_high) &&
                    (w_rdata.file_low == r_req.file_low) &&
                    (w_rdata.file_high == r_req.file_high);
    assign w_fmatch = (w_rdata.file_low == r_cfl) && (w_rdata.file_high == r_cfh);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        w_raddr = r_i[IDX_W-1:0];
        if (r_state == S_INNER && r_cvalid) begin
            w_raddr = r_j[IDX_W-1:0];
        end
        w_we    = 1'b0;
        w_waddr = r_count[IDX_W-1:0];
        w_wdata = '{r_req.peer_low, r_req.peer_high, r_req.file_low,
                    r_req.file_high, r_req.ip, r_req.port};
        if (r_state == S_DECIDE && r_req.op == OP_REG && !r_dup &&
            r_count != CNT_W'(ENTRIES)) begin
            w_we = 1'b1;
        end
        if (r_state == S_SHIFT && r_pend) begin
            w_we    = 1'b1;
            w_waddr = IDX_W'(r_i - CNT_W'(2));
            w_wdata = w_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ov <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= i_q_req;
                        r_i     <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_dup   <= 1'b0;
                        r_any   <= 1'b0;
                        if (i_q_req.bad) begin
                            r_ov <= 1'b1; r_ost <= ST_ERR; r_oe <= '0; r_olast <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        if (w_pair) begin
                            r_dup <= 1'b1;
                            r_hit <= IDX_W'(r_i - CNT_W'(1));
                        end
                        if (w_rdata.file_low == r_req.file_low &&
                            w_rdata.file_high == r_req.file_high) begin
                            r_found <= 1'b1;
                            r_cand  <= w_rdata;
                        end
                    end
                    if (r_i == r_count || (r_pend && w_pair && r_req.op != OP_SRCH)) begin
                        r_state <= S_DECIDE;
                        r_pend  <= 1'b0;
                    end else begin
                        r_pend <= 1'b1;
                        r_i    <= r_i + CNT_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_ov <= 1'b1; r_oe <= '0; r_olast <= 1'b1; r_ost <= ST_ERR;
                    r_state <= S_IDLE;
                    case (r_req.op)
                        OP_REG: begin
                            if (!r_dup && r_count != CNT_W'(ENTRIES)) begin
                                r_ost   <= ST_ACK;
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        OP_SRCH: begin
                            if (r_found) begin
                                r_ost <= ST_HIT; r_oe <= r_cand;
                            end
                        end
                        OP_DEREG: begin
                            if (r_dup) begin
                                r_ov    <= 1'b0;
                                r_state <= S_SHIFT;
                                r_i     <= CNT_W'(r_hit) + CNT_W'(1);
                                r_pend  <= 1'b0;
                            end
                        end
                        OP_LIST: begin
                            if (r_count != '0) begin
                                r_ov     <= 1'b0;
                                r_state  <= S_INNER;
                                r_i      <= '0;
                                r_j      <= '0;
                                r_pend   <= 1'b0;
                                r_cvalid <= 1'b0;
                                r_ofl_v  <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHIFT: begin
                    if (r_i == r_count) begin
                        r_count <= r_count - CNT_W'(1);
                        r_ov <= 1'b1; r_ost <= ST_ACK; r_oe <= '0; r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pend <= 1'b1;
                        r_i    <= r_i + CNT_W'(1);
                    end
                end
                S_INNER: begin
                    // load candidate at r_i, then compare against entries below it
                    if (!r_cvalid) begin
                        if (r_pend) begin
                            r_cvalid <= 1'b1;
                            r_cfl    <= w_rdata.file_low;
                            r_cfh    <= w_rdata.file_high;
                            r_pend   <= 1'b0;
                            r_j      <= '0;
                            r_any    <= 1'b0;
                        end else begin
                            r_j    <= r_i;
                            r_pend <= 1'b1;
                        end
                    end else if (r_pend && w_fmatch) begin
                        r_any   <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_j == r_i) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_pend <= 1'b1;
                        r_j    <= r_j + CNT_W'(1);
                    end
                end
                S_EMIT: begin
                    // hold the newest distinct name until the next one proves it is not last
                    if (!r_any) begin
                        if (r_ofl_v) begin
                            r_ov <= 1'b1; r_ost <= ST_NAME; r_olast <= 1'b0;
                            r_oe <= '{64'd0, 16'd0, r_pfl, r_pfh, 32'd0, 16'd0};
                        end
                        r_ofl_v <= 1'b1;
                        r_pfl   <= r_cfl;
                        r_pfh   <= r_cfh;
                    end
                    r_cvalid <= 1'b0;
                    r_pend   <= 1'b0;
                    r_i      <= r_i + CNT_W'(1);
                    if (r_i + CNT_W'(1) == r_count) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_INNER;
                    end
                end
                S_FLUSH: begin
                    r_ov    <= 1'b1;
                    r_ost   <= ST_NAME;
                    r_olast <= 1'b1;
                    r_oe    <= '{64'd0, 16'd0, r_pfl, r_pfh, 32'd0, 16'd0};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ov;
    assign o_status    = r_ost;
    assign o_peer_low  = r_oe.peer_low;
    assign o_peer_high = r_oe.peer_high;
    assign o_file_low  = r_oe.file_low;
    assign o_file_high = r_oe.file_high;
    assign o_ip        = r_oe.ip;
    assign o_port      = r_oe.port;
    assign o_last      = r_olast;
endmodule

### rtl/file_directory_table.sv
// Ordered directory of up to ENTRIES (peer, file, ip, port) entries held in one
// single-port-read RAM. Requests enter a two-deep queue; the back end walks the
// table one entry per cycle. The scan for a register or deregister stops at a
// matching entry; deregister then shifts the later entries down to close the
// gap. List compares each file name pairwise against the entries below it
// through the one-read-per-cycle RAM and emits each distinct name once.
// Results appear for one cycle on o_valid and cannot be stalled.
module file_directory_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_peer_name_low,
    input  logic [15:0] i_peer_name_high,
    input  logic [63:0] i_file_name_low,
    input  logic [15:0] i_file_name_high,
    input  logic [31:0] i_peer_ip,
    input  logic [15:0] i_peer_port,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_peer_low,
    output logic [15:0] o_out_peer_high,
    output logic [63:0] o_out_file_low,
    output logic [15:0] o_out_file_high,
    output logic [31:0] o_out_ip,
    output logic [15:0] o_out_port,
    output logic        o_last
);
    import fdt_pkg::*;

    logic w_qv, w_pop;
    t_req w_req;

    fdt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .o_busy(busy),
        .i_kind(i_kind), .i_peer_low(i_peer_name_low), .i_peer_high(i_peer_name_high),
        .i_file_low(i_file_name_low), .i_file_high(i_file_name_high),
        .i_ip(i_peer_ip), .i_port(i_peer_port),
        .o_q_valid(w_qv), .o_q_req(w_req), .i_q_pop(w_pop)
    );

    fdt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_req(w_req),
        .o_q_pop(w_pop), .o_valid(o_valid), .o_status(o_status),
        .o_peer_low(o_out_peer_low), .o_peer_high(o_out_peer_high),
        .o_file_low(o_out_file_low), .o_file_high(o_out_file_high),
        .o_ip(o_out_ip), .o_port(o_out_port), .o_last(o_last)
    );
endmodule
